// ----- sv/log2fp_pkg.sv -----
package log2fp_pkg;

	// field widths
	localparam int unsigned OperandWidth = 16;
	localparam int unsigned ResultWidth  = 12;

	// log2 format
	localparam int unsigned WholeWidth   = 4;
	localparam int unsigned FracBits     = 8;
	localparam int unsigned MantWidth    = 8;
	localparam int unsigned SquareWidth  = 2 * MantWidth;

	// mantissa bit that the leading one of the operand lands on
	localparam int unsigned NormPos      = MantWidth - 1;

	typedef logic [OperandWidth-1:0] operand_t;
	typedef logic [WholeWidth-1:0]   whole_t;
	typedef logic [MantWidth-1:0]    mant_t;
	typedef logic [FracBits-1:0]     frac_t;
	typedef logic [SquareWidth-1:0]  square_t;
	typedef logic [ResultWidth-1:0]  result_t;

endpackage

// ----- sv/log2_fixed_point_8_8.sv -----
// base-2 logarithm of a 16-bit unsigned operand, unsigned 4.8 result
// stages: encode, normalise, 8 squarings, each registered
// throughput: one item per cycle if unstalled; each stage holds one item till the next is free
// the 8x8 squaring stage sets the clock; a stalled output holds its item, stages behind fill up
// reset (arst_n low, asynchronous): all stage valid bits cleared, data registers not reset
module log2_fixed_point_8_8 (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [log2fp_pkg::OperandWidth-1:0] operand,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [log2fp_pkg::ResultWidth-1:0]  log_value
);

	localparam int unsigned NumSq = log2fp_pkg::FracBits;

	// stage 1: leading one position
	logic                  valid_s1;
	log2fp_pkg::operand_t  operand_s1;
	log2fp_pkg::whole_t    whole_s1;
	logic                  adv_s1;

	// stage 2: normalised mantissa
	logic                  valid_s2;
	log2fp_pkg::whole_t    whole_s2;
	log2fp_pkg::mant_t     mant_s2;
	logic                  adv_s2;

	// squaring stages, one fraction bit each
	logic                  sq_valid_s [NumSq];
	log2fp_pkg::whole_t    sq_whole_s [NumSq];
	log2fp_pkg::mant_t     sq_mant_s  [NumSq];
	log2fp_pkg::frac_t     sq_frac_s  [NumSq];
	logic                  sq_adv     [NumSq];

	log2fp_pkg::whole_t    whole_enc;
	logic [log2fp_pkg::OperandWidth+log2fp_pkg::NormPos-1:0] norm_wide;

	// advance chain: a stage may load when it is empty or its content moves on
	assign sq_adv[NumSq-1] = !sq_valid_s[NumSq-1] || !out_stall;
	for (genvar k = 0; k < NumSq - 1; k++) begin : g_adv
		assign sq_adv[k] = !sq_valid_s[k] || sq_adv[k+1];
	end
	assign adv_s2   = !valid_s2 || sq_adv[0];
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// priority encoder for the highest set bit of the incoming operand
	always_comb begin
		whole_enc = '0;
		for (int i = 1; i < log2fp_pkg::OperandWidth; i++) begin
			if (operand[i]) begin
				whole_enc = log2fp_pkg::WholeWidth'(i);
			end
		end
	end

	// shift so the leading one lands on the mantissa msb
	assign norm_wide = {operand_s1, {log2fp_pkg::NormPos{1'b0}}} >> whole_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			operand_s1 <= operand;
			whole_s1   <= whole_enc;
		end
		if (adv_s2 && valid_s1) begin
			whole_s2 <= whole_s1;
			mant_s2  <= norm_wide[log2fp_pkg::MantWidth-1:0];
		end
	end

	// squaring pipeline
	for (genvar k = 0; k < NumSq; k++) begin : g_sq
		logic                 src_valid;
		log2fp_pkg::whole_t   src_whole;
		log2fp_pkg::mant_t    src_mant;
		log2fp_pkg::frac_t    src_frac;
		log2fp_pkg::square_t  square;
		logic                 bit_set;
		log2fp_pkg::mant_t    next_mant;

		if (k == 0) begin : g_first
			assign src_valid = valid_s2;
			assign src_whole = whole_s2;
			assign src_mant  = mant_s2;
			assign src_frac  = '0;
		end else begin : g_rest
			assign src_valid = sq_valid_s[k-1];
			assign src_whole = sq_whole_s[k-1];
			assign src_mant  = sq_mant_s[k-1];
			assign src_frac  = sq_frac_s[k-1];
		end

		// a square of a normalised mantissa is never exactly 2.0, so the msb decides
		assign square    = log2fp_pkg::SquareWidth'(src_mant) * log2fp_pkg::SquareWidth'(src_mant);
		assign bit_set   = square[log2fp_pkg::SquareWidth-1];
		assign next_mant = bit_set ? square[log2fp_pkg::SquareWidth-1 -: log2fp_pkg::MantWidth]
		                           : square[log2fp_pkg::SquareWidth-2 -: log2fp_pkg::MantWidth];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_valid_s[k] <= 1'b0;
			end else if (sq_adv[k]) begin
				sq_valid_s[k] <= src_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (sq_adv[k] && src_valid) begin
				sq_whole_s[k] <= src_whole;
				sq_mant_s[k]  <= next_mant;
				sq_frac_s[k]  <= {src_frac[log2fp_pkg::FracBits-2:0], bit_set};
			end
		end
	end

	// output from the last squaring stage
	assign out_valid = sq_valid_s[NumSq-1];
	assign log_value = {sq_whole_s[NumSq-1], sq_frac_s[NumSq-1]};

	// a nonzero integer part always comes with a normalised mantissa
	a_norm_msb: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (whole_s2 != '0) |-> mant_s2[log2fp_pkg::MantWidth-1])
		else $error("mantissa not normalised");

	// a zero mantissa only comes from operand zero
	a_zero_mant: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (mant_s2 == '0) |-> (whole_s2 == '0))
		else $error("zero mantissa with nonzero integer part");

	// the first squaring stage keeps the mantissa in range
	a_sq_norm: assert property (@(posedge clk) disable iff (!arst_n)
		sq_valid_s[0] && (sq_mant_s[0] != '0) |-> sq_mant_s[0][log2fp_pkg::MantWidth-1])
		else $error("squared mantissa out of range");

	// the input only stalls when the first stage holds a blocked item
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_valid && out_stall)
		else $error("input stalled with room in the pipeline");

endmodule

// ----- tb/log2_fixed_point_8_8_checker.sv -----
`timescale 1ns / 1ps

module log2_fixed_point_8_8_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  log2fp_pkg::operand_t operand,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  log2fp_pkg::result_t  log_value,
	output int unsigned          failures,
	output int unsigned          pending
);

	// a square above this (2.0) is halved for the next mantissa: fraction bit set
	localparam log2fp_pkg::square_t HalfScale = log2fp_pkg::square_t'(1 << 15);

	typedef struct packed {
		log2fp_pkg::operand_t operand;
		log2fp_pkg::result_t  log_value;
	} log_entry_t;

	log_entry_t expected_logs [$];

	initial begin
		failures = 0;
		pending  = 0;
	end

	// log2 in 4.8: leading one position, then one fraction bit per squaring
	function automatic log2fp_pkg::result_t predict_log2(log2fp_pkg::operand_t v);
		log2fp_pkg::whole_t  whole;
		log2fp_pkg::square_t mant;
		log2fp_pkg::square_t sq;
		log2fp_pkg::frac_t   frac;
		whole = '0;
		frac  = '0;
		for (int i = 0; i < log2fp_pkg::OperandWidth; i++) begin
			if (v[i])
				whole = log2fp_pkg::whole_t'(i);
		end
		if (whole > log2fp_pkg::NormPos)
			mant = log2fp_pkg::square_t'(v >> (whole - log2fp_pkg::NormPos));
		else
			mant = log2fp_pkg::square_t'(v << (log2fp_pkg::NormPos - whole));
		for (int k = 0; k < log2fp_pkg::FracBits; k++) begin
			sq   = mant * mant;
			frac = {frac[log2fp_pkg::FracBits-2:0], 1'b0};
			if (sq > HalfScale) begin
				frac[0] = 1'b1;
				mant    = sq >> log2fp_pkg::MantWidth;
			end else begin
				mant    = sq >> log2fp_pkg::NormPos;
			end
		end
		return {whole, frac};
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		failures++;
	endtask

	// compare each accepted result with the oldest prediction, then queue new ones
	always @(posedge clk) begin
		log_entry_t oldest;
		log_entry_t fresh;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_logs.size() == 0) begin
					report_mismatch($sformatf("unexpected result log_value=%0h", log_value));
				end else begin
					oldest = expected_logs.pop_front();
					if (log_value !== oldest.log_value)
						report_mismatch($sformatf("operand=%04h log_value=%03h expected %03h",
							oldest.operand, log_value, oldest.log_value));
				end
			end
			if (in_valid && !in_stall) begin
				fresh.operand   = operand;
				fresh.log_value = predict_log2(operand);
				expected_logs.push_back(fresh);
			end
			pending = expected_logs.size();
		end
	end

endmodule

// ----- tb/log2_fixed_point_8_8_tb.sv -----
`timescale 1ns / 1ps

module log2_fixed_point_8_8_tb;

	localparam int unsigned RandomItems = 1400;
	localparam int unsigned DrainCycles = 30;
	localparam int unsigned CycleLimit  = 300000;

	typedef enum logic [1:0] {
		StallNone,
		StallCoin,
		StallHeavy,
		StallPeriodic
	} stall_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	log2fp_pkg::operand_t operand = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	log2fp_pkg::result_t  log_value;
	int unsigned          failures;
	int unsigned          pending;
	int unsigned          cycle_count = 0;
	stall_mode_t          stall_mode = StallNone;
	int unsigned          hold_left = 0;

	log2_fixed_point_8_8 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operand   (operand),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.log_value (log_value)
	);

	log2_fixed_point_8_8_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operand   (operand),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.log_value (log_value),
		.failures  (failures),
		.pending   (pending)
	);

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("log2_fixed_point_8_8 regression: fail");
			$finish;
		end
	end

	// receiver stall: switches between quiet, coin-flip, heavy and periodic spells
	always @(negedge clk) begin
		if (hold_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			hold_left  <= $urandom_range(20, 200);
		end else begin
			hold_left  <= hold_left - 1;
		end
		case (stall_mode)
			StallNone:     out_stall <= 1'b0;
			StallCoin:     out_stall <= ($urandom_range(0, 1) == 1);
			StallHeavy:    out_stall <= ($urandom_range(0, 9) < 8);
			StallPeriodic: out_stall <= (hold_left[2:0] < 3);
		endcase
	end

	// present one item at a falling edge and hold it until taken
	task automatic send_operand(input log2fp_pkg::operand_t v);
		in_valid = 1'b1;
		operand  = v;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	initial begin
		log2fp_pkg::operand_t corner_operands [24];
		int unsigned sent;
		int unsigned burst;
		int unsigned gap;
		int unsigned span;

		corner_operands = '{
			16'h0000, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0007,
			16'h007F, 16'h0080, 16'h0081, 16'h00FF, 16'h0100, 16'h0101,
			16'h0181, 16'h5555, 16'hAAAA, 16'h00B5, 16'h7FFF, 16'h8000,
			16'h8001, 16'hFF00, 16'hFFFE, 16'hFFFF, 16'h0000, 16'h0001
		};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed corners, partly back to back
		foreach (corner_operands[i]) begin
			send_operand(corner_operands[i]);
			if ($urandom_range(0, 2) == 0) begin
				in_valid = 1'b0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
			end
		end

		// random bursts; half the items use a random magnitude so every
		// leading-one position shows up often
		sent = 0;
		while (sent < RandomItems) begin
			burst = $urandom_range(1, 32);
			gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			for (int j = 0; j < burst && sent < RandomItems; j++) begin
				if ($urandom_range(0, 1) == 0) begin
					send_operand(log2fp_pkg::operand_t'($urandom));
				end else begin
					span = $urandom_range(0, log2fp_pkg::OperandWidth);
					send_operand(log2fp_pkg::operand_t'($urandom & ((32'd1 << span) - 1)));
				end
				sent++;
			end
			if (gap != 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_valid = 1'b0;

		// drain
		wait (pending == 0);
		repeat (DrainCycles) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("log2_fixed_point_8_8 regression: pass");
		else
			$display("log2_fixed_point_8_8 regression: fail");
		$finish;
	end

endmodule
